@@ design/rspg_pkg.sv @@
// ----------------------------------------------------------------------------
// Reed-Solomon parity generator package
// Shared types, reset values, register codes and the GF(256) multiply.
// ----------------------------------------------------------------------------
package rspg_pkg;

  localparam int MAX_PARITY_DEFAULT = 32;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] CFG_PARITY_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIELD_POLY   = 1'b1;

  localparam logic [5:0] PARITY_COUNT_RESET = 6'd10;
  localparam logic [7:0] FIELD_POLY_RESET   = 8'h1D;

  typedef struct packed {
    logic       func;
    logic [4:0] coef_index;
    logic [7:0] value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] parity_byte;
    logic       last_parity;
  } out_item_t;

  typedef struct packed {
    logic       msg;
    logic [4:0] coef_index;
    logic [7:0] value;
    logic       last;
  } cmd_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] red);
    logic [7:0] x;
    logic [7:0] acc;
    x   = a;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= x;
      x = x[7] ? ({x[6:0], 1'b0} ^ red) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

@@ design/rspg_stream_if.sv @@
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface rspg_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/rspg_front.sv @@
// ----------------------------------------------------------------------------
// Front end
// Accepts input items, drops out-of-range coefficient loads, queues commands.
// ----------------------------------------------------------------------------
module rspg_front import rspg_pkg::*; #(
  parameter int MAX_PARITY = MAX_PARITY_DEFAULT
) (
  rspg_stream_if.sink message,
  input  logic        full,
  output logic        push,
  output cmd_t        push_cmd
);

  logic keep;

  assign keep             = message.data.func || (32'(message.data.coef_index) < MAX_PARITY);
  assign message.ready    = !full;
  assign push             = message.valid && !full && keep;
  assign push_cmd.msg        = message.data.func;
  assign push_cmd.coef_index = message.data.coef_index;
  assign push_cmd.value      = message.data.value;
  assign push_cmd.last       = message.data.func && message.data.last_byte;

endmodule

@@ design/rspg_queue.sv @@
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue between the front end and the encoder back end.
// ----------------------------------------------------------------------------
module rspg_queue import rspg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;
  logic          do_pop;

  assign full      = (count == (PW+1)'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entries[rptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + PW'(1);
      if (do_pop) rptr <= rptr + PW'(1);
      if (push && !do_pop) begin
        count <= count + (PW+1)'(1);
      end else if (do_pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

@@ design/rspg_back.sv @@
// ----------------------------------------------------------------------------
// Encoder back end
// Generator store, parallel LFSR remainder; one command per cycle while ready.
// ----------------------------------------------------------------------------
module rspg_back import rspg_pkg::*; #(
  parameter int MAX_PARITY = MAX_PARITY_DEFAULT,
  localparam int AW = $clog2(MAX_PARITY),
  localparam int NW = $clog2(MAX_PARITY + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  cmd_t          cmd,
  output logic          cmd_ready,
  input  logic [NW-1:0] n_eff,
  input  logic [7:0]    red,
  input  logic          emit_free,
  output logic          emit_load,
  output logic [7:0]    emit_bytes [MAX_PARITY]
);

  logic [7:0]    gen      [MAX_PARITY];
  logic [7:0]    rem      [MAX_PARITY];
  logic [7:0]    rem_next [MAX_PARITY];
  logic [AW-1:0] top_idx;
  logic [7:0]    fb;
  logic          pop;
  logic          msg_pop;

  assign top_idx   = AW'(n_eff - NW'(1));
  assign fb        = cmd.value ^ rem[top_idx];
  assign cmd_ready = !cmd.last || emit_free;
  assign pop       = cmd_valid && cmd_ready;
  assign msg_pop   = pop && cmd.msg;
  assign emit_load = msg_pop && cmd.last;

  for (genvar i = 0; i < MAX_PARITY; i++) begin : g_stage
    if (i == 0) begin : g_low
      assign rem_next[i] = gf_mul(fb, gen[i], red);
    end else begin : g_high
      assign rem_next[i] = (32'(n_eff) > i) ? (rem[i-1] ^ gf_mul(fb, gen[i], red)) : rem[i];
    end
    assign emit_bytes[i] = rem_next[i];
  end

  always_ff @(posedge clk) begin
    if (pop && !cmd.msg) begin
      for (int j = 0; j < MAX_PARITY; j++) begin
        if (32'(cmd.coef_index) == j) gen[j] <= cmd.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || emit_load) begin
      for (int j = 0; j < MAX_PARITY; j++) rem[j] <= '0;
    end else if (msg_pop) begin
      rem <= rem_next;
    end
  end

endmodule

@@ design/rspg_emit.sv @@
// ----------------------------------------------------------------------------
// Parity emitter
// Holds a captured remainder and shifts it out, highest degree first.
// ----------------------------------------------------------------------------
module rspg_emit import rspg_pkg::*; #(
  parameter int MAX_PARITY = MAX_PARITY_DEFAULT,
  localparam int AW = $clog2(MAX_PARITY),
  localparam int NW = $clog2(MAX_PARITY + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic [7:0]    load_bytes [MAX_PARITY],
  input  logic [NW-1:0] load_count,
  output logic          free,
  rspg_stream_if.source parity
);

  logic [7:0]    shadow [MAX_PARITY];
  logic [NW-1:0] count;
  logic [AW-1:0] top_idx;
  logic          adv;

  assign adv  = (count != '0) && (!parity.valid || parity.ready);
  assign free = (count == '0) || ((count == NW'(1)) && adv);

  always_ff @(posedge clk) begin
    if (adv) begin
      parity.data.parity_byte <= shadow[top_idx];
      parity.data.last_parity <= (count == NW'(1));
    end
    if (load) begin
      shadow  <= load_bytes;
      top_idx <= AW'(load_count - NW'(1));
    end else if (adv) begin
      for (int j = MAX_PARITY - 1; j > 0; j--) shadow[j] <= shadow[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      parity.valid <= 1'b0;
    end else begin
      if (adv) begin
        parity.valid <= 1'b1;
      end else if (parity.ready) begin
        parity.valid <= 1'b0;
      end
      if (load) begin
        count <= load_count;
      end else if (adv) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

@@ design/reed_solomon_parity_generator.sv @@
// ----------------------------------------------------------------------------
// Reed-Solomon parity generator
// GF(256) parity over a loaded monic generator, parallel LFSR remainder.
//
//   Channel   Role     Payload                                  Accepted when
//   message   sink     func, coef_index, value, last_byte       valid && ready
//   parity    source   parity_byte, last_parity                 valid && ready
//   cfg       write    cfg_index, cfg_data                      cfg_we
//
// One input item per clock; a message byte updates all remainder bytes at once.
// A last byte moves n bytes to the output register, one per clock while ready.
// A further last byte waits at the head of the queue until the previous run's
// final byte has been moved into the output register; items behind it are held
// and the input stalls once the two-entry queue is full.
// rst clears the queue, remainder and output valid and returns the config
// registers to their reset values; the generator store is not cleared.
// A run's last byte is queued; its remainder then enters the emitter shadow.
// ----------------------------------------------------------------------------
module reed_solomon_parity_generator import rspg_pkg::*; #(
  parameter int MAX_PARITY = MAX_PARITY_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  rspg_stream_if.sink            message,
  rspg_stream_if.source          parity,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int NW = $clog2(MAX_PARITY + 1);

  logic [5:0]    parity_count;
  logic [7:0]    field_poly;
  logic [NW-1:0] n_eff;

  logic          push;
  cmd_t          push_cmd;
  logic          full;
  logic          cmd_valid;
  cmd_t          cmd;
  logic          cmd_ready;
  logic          emit_free;
  logic          emit_load;
  logic [7:0]    emit_bytes [MAX_PARITY];

  always_ff @(posedge clk) begin
    if (rst) begin
      parity_count <= PARITY_COUNT_RESET;
      field_poly   <= FIELD_POLY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PARITY_COUNT: parity_count <= cfg_data[5:0];
        CFG_FIELD_POLY:   field_poly   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (parity_count == '0) begin
      n_eff = NW'(1);
    end else if (32'(parity_count) > MAX_PARITY) begin
      n_eff = NW'(MAX_PARITY);
    end else begin
      n_eff = NW'(parity_count);
    end
  end

  rspg_front #(.MAX_PARITY(MAX_PARITY)) u_front (
    .message  (message),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  rspg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop_valid (cmd_valid),
    .pop_cmd   (cmd),
    .pop       (cmd_ready)
  );

  rspg_back #(.MAX_PARITY(MAX_PARITY)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_ready  (cmd_ready),
    .n_eff      (n_eff),
    .red        (field_poly),
    .emit_free  (emit_free),
    .emit_load  (emit_load),
    .emit_bytes (emit_bytes)
  );

  rspg_emit #(.MAX_PARITY(MAX_PARITY)) u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (emit_load),
    .load_bytes (emit_bytes),
    .load_count (n_eff),
    .free       (emit_free),
    .parity     (parity)
  );

endmodule

@@ tb/tb_reed_solomon_parity_generator.sv @@
// ----------------------------------------------------------------------------
// Reed-Solomon parity generator testbench
// Loads a generator, streams message bytes through the message channel and
// checks every parity byte against a GF(256) remainder predictor held here.
// Directed cases cover the register extremes, the saturated parity count, a
// field polynomial without bit 8, a count change in the middle of a message
// and ignored last flags on loads. Random runs follow under several settings
// with random idling on both channels, turned off for the final setting.
// ----------------------------------------------------------------------------
module tb_reed_solomon_parity_generator;
  import rspg_pkg::*;

  localparam int NUM_COEF      = 32;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_ITEMS   = 48;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  rspg_stream_if #(.T(in_item_t))  msg_if ();
  rspg_stream_if #(.T(out_item_t)) par_if ();

  reed_solomon_parity_generator dut (
    .clk      (clk),
    .rst      (rst),
    .message  (msg_if),
    .parity   (par_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  logic [7:0] gen_coef [NUM_COEF];
  logic [7:0] rem_bytes [NUM_COEF];
  logic [5:0] n_reg;
  logic [8:0] poly_reg;
  out_item_t  parity_expected [$];

  int  errors;
  int  items_sent;
  int  bytes_checked;
  int  runs_done;
  int  cycle_count;
  bit  src_idle_on;
  bit  sink_idle_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b,
                                           input logic [8:0] poly);
    logic [7:0] acc;
    acc = '0;
    for (int k = 7; k >= 0; k--) begin
      acc = acc[7] ? ({acc[6:0], 1'b0} ^ poly[7:0]) : {acc[6:0], 1'b0};
      if (b[k]) acc ^= a;
    end
    return acc;
  endfunction

  task automatic predict_parity(input in_item_t it);
    int unsigned n;
    logic [7:0]  fb;
    out_item_t   e;
    if (!it.func) begin
      gen_coef[it.coef_index] = it.value;
    end else begin
      n = (n_reg == 0) ? 1 : ((n_reg > NUM_COEF) ? NUM_COEF : n_reg);
      fb = it.value ^ rem_bytes[n-1];
      for (int i = n - 1; i > 0; i--)
        rem_bytes[i] = rem_bytes[i-1] ^ field_mul(fb, gen_coef[i], poly_reg);
      rem_bytes[0] = field_mul(fb, gen_coef[0], poly_reg);
      if (it.last_byte) begin
        for (int i = 0; i < n; i++) begin
          e.parity_byte = rem_bytes[n-1-i];
          e.last_parity = (i == n - 1);
          parity_expected.push_back(e);
        end
        for (int i = 0; i < NUM_COEF; i++) rem_bytes[i] = '0;
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst) begin
      if (par_if.valid && par_if.ready) begin
        if (parity_expected.size() == 0) begin
          errors++;
          $display("%0t unexpected parity item: expected none actual %02h/%0b", $time,
                   par_if.data.parity_byte, par_if.data.last_parity);
        end else begin
          e = parity_expected.pop_front();
          bytes_checked++;
          if (par_if.data.parity_byte !== e.parity_byte) begin
            errors++;
            $display("%0t parity_byte mismatch: expected %02h actual %02h", $time,
                     e.parity_byte, par_if.data.parity_byte);
          end
          if (par_if.data.last_parity !== e.last_parity) begin
            errors++;
            $display("%0t last_parity mismatch: expected %0b actual %0b", $time,
                     e.last_parity, par_if.data.last_parity);
          end
          if (e.last_parity) runs_done++;
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_PARITY_COUNT) n_reg = cfg_data[5:0];
        else poly_reg = cfg_data;
      end
      if (msg_if.valid && msg_if.ready) predict_parity(msg_if.data);
    end
  end

  initial begin
    par_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        par_if.ready = 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        par_if.ready = 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t timeout with %0d parity items outstanding", $time, parity_expected.size());
    $display("tb: failure");
    $finish;
  end

  function automatic in_item_t make_item(input logic func, input logic [4:0] idx,
                                         input logic [7:0] value, input logic last);
    in_item_t it;
    it.func       = func;
    it.coef_index = idx;
    it.value      = value;
    it.last_byte  = last;
    return it;
  endfunction

  // call at a falling edge; returns at a falling edge with valid still high
  task automatic send_item(input in_item_t it);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      msg_if.valid = 1'b0;
      msg_if.data  = in_item_t'($urandom);
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    msg_if.valid = 1'b1;
    msg_if.data  = it;
    do @(posedge clk); while (!msg_if.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] value, input logic last);
    send_item(make_item(1'b1, 5'($urandom), value, last));
  endtask

  task automatic wait_idle();
    msg_if.valid = 1'b0;
    while (parity_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic test_load_generator();
    for (int i = 0; i < NUM_COEF; i++) begin
      logic [7:0] v;
      v = (i == 0) ? 8'hFF : ((i == 1) ? 8'h00 : 8'($urandom));
      send_item(make_item(1'b0, 5'(i), v, 1'($urandom)));
    end
  endtask

  task automatic test_default_settings();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_item(make_item(1'b0, 5'd31, 8'hA5, 1'b1));
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_parity_count_extremes();
    write_reg(CFG_PARITY_COUNT, 9'd1);
    send_byte(8'h5A, 1'b1);
    write_reg(CFG_PARITY_COUNT, 9'd32);
    send_byte(8'h01, 1'b0);
    send_byte(8'hC3, 1'b1);
    write_reg(CFG_PARITY_COUNT, 9'd0);
    send_byte(8'h37, 1'b1);
    write_reg(CFG_PARITY_COUNT, 9'd63);
    send_byte(8'hE1, 1'b1);
  endtask

  task automatic test_field_polynomials();
    write_reg(CFG_PARITY_COUNT, 9'd4);
    write_reg(CFG_FIELD_POLY, 9'h01D);
    send_byte(8'h9C, 1'b0);
    send_byte(8'hF0, 1'b1);
    write_reg(CFG_FIELD_POLY, 9'h1FF);
    send_byte(8'hFF, 1'b1);
    write_reg(CFG_FIELD_POLY, 9'h100);
    send_byte(8'h81, 1'b1);
    write_reg(CFG_FIELD_POLY, 9'h000);
    send_byte(8'hAA, 1'b1);
    write_reg(CFG_FIELD_POLY, 9'h11D);
  endtask

  task automatic test_count_change_mid_message();
    write_reg(CFG_PARITY_COUNT, 9'd8);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    write_reg(CFG_PARITY_COUNT, 9'd4);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);
    write_reg(CFG_PARITY_COUNT, 9'd8);
    send_byte(8'h9A, 1'b1);
  endtask

  task automatic send_random_run(inout int phase_items);
    int len;
    len = $urandom_range(1, 12);
    for (int j = 0; j < len; j++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(make_item(1'b0, 5'($urandom), 8'($urandom), 1'($urandom)));
        phase_items++;
      end
      send_byte(8'($urandom), j == len - 1);
      phase_items++;
    end
  endtask

  task automatic test_random_traffic();
    logic [5:0] counts [6];
    logic [8:0] polys [6];
    int         phase_items;
    counts = '{6'd1, 6'd32, 6'($urandom_range(2, 31)), 6'($urandom_range(2, 31)),
               ($urandom_range(0, 1) != 0) ? 6'd0 : 6'd63, 6'($urandom_range(1, 16))};
    polys  = '{9'h11D, 9'h1FF, 9'h100, 9'($urandom_range(256, 511)),
               9'($urandom_range(0, 255)), 9'h11D};
    for (int p = 0; p < 6; p++) begin
      if (p == 5) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end
      write_reg(CFG_PARITY_COUNT, {3'b000, counts[p]});
      write_reg(CFG_FIELD_POLY, polys[p]);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) send_random_run(phase_items);
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    msg_if.valid = 1'b0;
    msg_if.data  = '0;
    errors        = 0;
    items_sent    = 0;
    bytes_checked = 0;
    runs_done     = 0;
    src_idle_on   = 1'b1;
    sink_idle_on  = 1'b1;
    n_reg    = PARITY_COUNT_RESET;
    poly_reg = {1'b1, FIELD_POLY_RESET};
    for (int i = 0; i < NUM_COEF; i++) begin
      gen_coef[i]  = '0;
      rem_bytes[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_load_generator();
    test_default_settings();
    test_parity_count_extremes();
    test_field_polynomials();
    test_count_change_mid_message();
    test_random_traffic();

    wait_idle();
    if (parity_expected.size() != 0) begin
      errors++;
      $display("%0t %0d parity items never arrived", $time, parity_expected.size());
    end
    $display("summary: %0d message items accepted, %0d parity bytes in %0d runs checked",
             items_sent, bytes_checked, runs_done);
    $display("summary: parity counts 0 to 63 and field polynomials with and without bit 8");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
